### hdl/rotary_dial_pulse_decoder_unit_defines.svh
// Assertion macros for the rotary dial pulse decoder.
`ifndef ROTARY_DIAL_PULSE_DECODER_UNIT_DEFINES_SVH
`define ROTARY_DIAL_PULSE_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RDPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rdpd: check failed");
`define RDPD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rdpd: sequence check failed");
`else
`define RDPD_ASSERT(lbl, prop)
`define RDPD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### hdl/rdpd_pkg.sv
// Shared constants and types of the rotary dial pulse decoder.
package rdpd_pkg;

    localparam int unsigned DebW   = 8;
    localparam int unsigned PulseW = 10;
    localparam int unsigned DigitW = 16;
    localparam int unsigned CountW = 4;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned IdxW   = 2;

    localparam logic [DebW-1:0]   DEBOUNCE_RST = 8'd25;
    localparam logic [PulseW-1:0] PULSE_TO_RST = 10'd84;
    localparam logic [DigitW-1:0] DIGIT_TO_RST = 16'd4000;
    localparam logic [CountW-1:0] COUNT_MAX    = 4'd15;
    localparam logic [CountW-1:0] DIGIT_BASE   = 4'd10;

    localparam logic [IdxW-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [IdxW-1:0] CFG_PULSE_TO = 2'd1;
    localparam logic [IdxW-1:0] CFG_DIGIT_TO = 2'd2;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_PULSE = 3'd1;
    localparam logic [2:0] PH_LOW        = 3'd2;
    localparam logic [2:0] PH_WAIT_NEXT  = 3'd3;
    localparam logic [2:0] PH_DONE       = 3'd4;

    typedef struct packed {
        logic level;
        logic rise;
        logic fall;
    } t_deb;

endpackage

### hdl/rdpd_debounce.sv
// Hook switch debouncer: hold counter and accepted level, edge detection.
module rdpd_debounce (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_raw,
    input  logic [rdpd_pkg::DebW-1:0] i_debounce_ticks,
    output rdpd_pkg::t_deb            o_deb
);

    logic [rdpd_pkg::DebW-1:0] r_hold;
    logic [rdpd_pkg::DebW-1:0] n_hold;
    logic [rdpd_pkg::DebW-1:0] w_hold_inc;
    logic                      r_level;

    assign w_hold_inc = (r_hold != '1) ? r_hold + 1'b1 : r_hold;

    always_comb begin
        n_hold       = '0;
        o_deb.level  = r_level;
        o_deb.rise   = 1'b0;
        o_deb.fall   = 1'b0;
        if (i_raw != r_level) begin
            n_hold = w_hold_inc;
            if (w_hold_inc >= i_debounce_ticks) begin
                n_hold      = '0;
                o_deb.level = i_raw;
                o_deb.rise  = i_raw;
                o_deb.fall  = ~i_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '0;
            r_level <= 1'b0;
        end else if (i_adv) begin
            r_hold  <= n_hold;
            r_level <= o_deb.level;
        end
    end

endmodule

### hdl/rotary_dial_pulse_decoder_unit.sv
// Top level of the rotary dial pulse decoder: session control and result register.
//
// One input beat carries one raw hook sample, taken once per millisecond tick.
// Every input beat yields exactly one output beat with the debounced hook
// level, pick-up and put-down edges, dial tone request, a digit when a pulse
// train ends, a pulse error, number complete and hang-up flags.
// The result of a beat is on the output in the cycle after acceptance.
// Throughput: one beat per cycle; the whole tick update sits between the
// state registers and the result register.
// A held result does not block the input as long as the receiver takes it in
// the same cycle; while the receiver stalls with a result pending, o_in_ready
// drops and the state stands still.
// Synchronous reset clears the session to idle, on hook, tone off, empties the
// result register and loads the timing registers with 25, 84 and 4000 ticks. Timing
// registers go through i_cfg_we / i_cfg_idx / i_cfg_data, index 0 debounce, 1 pulse
// timeout, 2 digit timeout. The user must write them only while the block is idle; it is not enforced.
`include "rotary_dial_pulse_decoder_unit_defines.svh"
module rotary_dial_pulse_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rdpd_pkg::IdxW-1:0]   i_cfg_idx,
    input  logic [rdpd_pkg::CfgW-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_hook_raw,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hook_level,
    output logic                        o_picked_up,
    output logic                        o_put_down,
    output logic                        o_tone_on,
    output logic                        o_digit_valid,
    output logic [rdpd_pkg::CountW-1:0] o_digit,
    output logic                        o_pulse_error,
    output logic                        o_number_done,
    output logic                        o_hung_up
);

    logic [rdpd_pkg::DebW-1:0]   r_debounce_ticks;
    logic [rdpd_pkg::PulseW-1:0] r_pulse_to;
    logic [rdpd_pkg::DigitW-1:0] r_digit_to;

    logic [2:0]                  r_phase,   n_phase;
    logic [rdpd_pkg::PulseW-1:0] r_ptimer,  n_ptimer;
    logic [rdpd_pkg::CountW-1:0] r_pcount,  n_pcount;
    logic [rdpd_pkg::DigitW-1:0] r_dtimer,  n_dtimer;
    logic                        r_any,     n_any;
    logic                        r_tone,    n_tone;
    logic                        r_out_valid;

    logic [rdpd_pkg::PulseW-1:0] w_pt_inc;
    logic [rdpd_pkg::DigitW-1:0] w_dt_inc;
    logic [rdpd_pkg::CountW-1:0] w_pc_inc;
    logic                        w_accept;
    logic                        w_dvalid, w_perr, w_ndone, w_hung;
    logic [rdpd_pkg::CountW-1:0] w_dval;
    rdpd_pkg::t_deb              w_deb;

    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign w_accept    = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;

    rdpd_debounce u_deb (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_accept),
        .i_raw            (i_hook_raw),
        .i_debounce_ticks (r_debounce_ticks),
        .o_deb            (w_deb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= rdpd_pkg::DEBOUNCE_RST;
            r_pulse_to       <= rdpd_pkg::PULSE_TO_RST;
            r_digit_to       <= rdpd_pkg::DIGIT_TO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rdpd_pkg::CFG_DEBOUNCE: r_debounce_ticks <= i_cfg_data[rdpd_pkg::DebW-1:0];
                rdpd_pkg::CFG_PULSE_TO: r_pulse_to       <= i_cfg_data[rdpd_pkg::PulseW-1:0];
                rdpd_pkg::CFG_DIGIT_TO: r_digit_to       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_pt_inc = (r_ptimer != '1) ? r_ptimer + 1'b1 : r_ptimer;
    assign w_dt_inc = (r_dtimer != '1) ? r_dtimer + 1'b1 : r_dtimer;
    assign w_pc_inc = (r_pcount != rdpd_pkg::COUNT_MAX) ? r_pcount + 1'b1 : r_pcount;

    always_comb begin
        n_phase  = r_phase;
        n_ptimer = r_ptimer;
        n_pcount = r_pcount;
        n_dtimer = r_dtimer;
        n_any    = r_any;
        n_tone   = r_tone;
        w_dvalid = 1'b0;
        w_dval   = '0;
        w_perr   = 1'b0;
        w_ndone  = 1'b0;
        w_hung   = 1'b0;
        case (r_phase)
            rdpd_pkg::PH_WAIT_PULSE: begin
                if (w_deb.fall) begin
                    n_phase  = rdpd_pkg::PH_LOW;
                    n_ptimer = '0;
                    n_tone   = 1'b0;
                end else if (r_any) begin
                    n_dtimer = w_dt_inc;
                    if (w_dt_inc >= r_digit_to) begin
                        w_ndone = 1'b1;
                        n_tone  = 1'b0;
                        n_phase = rdpd_pkg::PH_DONE;
                    end
                end
            end
            rdpd_pkg::PH_LOW: begin
                if (w_deb.rise) begin
                    n_pcount = w_pc_inc;
                    n_ptimer = '0;
                    n_phase  = rdpd_pkg::PH_WAIT_NEXT;
                end else begin
                    n_ptimer = w_pt_inc;
                    if (w_pt_inc >= r_pulse_to) begin
                        w_perr   = 1'b1;
                        w_hung   = 1'b1;
                        n_pcount = '0;
                        n_ptimer = '0;
                        n_tone   = 1'b0;
                        n_phase  = rdpd_pkg::PH_IDLE;
                    end
                end
            end
            rdpd_pkg::PH_WAIT_NEXT: begin
                if (w_deb.fall) begin
                    n_ptimer = '0;
                    n_phase  = rdpd_pkg::PH_LOW;
                    n_tone   = 1'b0;
                end else begin
                    n_ptimer = w_pt_inc;
                    if (w_pt_inc >= r_pulse_to) begin
                        w_dvalid = 1'b1;
                        w_dval   = (r_pcount >= rdpd_pkg::DIGIT_BASE)
                                   ? r_pcount - rdpd_pkg::DIGIT_BASE : r_pcount;
                        n_any    = 1'b1;
                        n_dtimer = '0;
                        n_pcount = '0;
                        n_ptimer = '0;
                        n_phase  = rdpd_pkg::PH_WAIT_PULSE;
                    end
                end
            end
            rdpd_pkg::PH_DONE: begin
                if (w_deb.fall) begin
                    n_phase = rdpd_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = rdpd_pkg::PH_IDLE;
                if (w_deb.rise) begin
                    n_phase  = rdpd_pkg::PH_WAIT_PULSE;
                    n_tone   = 1'b1;
                    n_pcount = '0;
                    n_ptimer = '0;
                    n_dtimer = '0;
                    n_any    = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rdpd_pkg::PH_IDLE;
            r_ptimer    <= '0;
            r_pcount    <= '0;
            r_dtimer    <= '0;
            r_any       <= 1'b0;
            r_tone      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase  <= n_phase;
                r_ptimer <= n_ptimer;
                r_pcount <= n_pcount;
                r_dtimer <= n_dtimer;
                r_any    <= n_any;
                r_tone   <= n_tone;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_hook_level  <= w_deb.level;
            o_picked_up   <= w_deb.rise;
            o_put_down    <= w_deb.fall;
            o_tone_on     <= n_tone;
            o_digit_valid <= w_dvalid;
            o_digit       <= w_dval;
            o_pulse_error <= w_perr;
            o_number_done <= w_ndone;
            o_hung_up     <= w_hung;
        end
    end

    `RDPD_ASSERT(a_edge_excl, !(o_out_valid && o_picked_up && o_put_down))
    `RDPD_ASSERT(a_digit_range, o_out_valid |-> (o_digit <= 4'd9))
    `RDPD_ASSERT(a_hung_err, (o_out_valid && o_hung_up) |-> (o_pulse_error && !o_tone_on))
    `RDPD_ASSERT(a_idle_quiet, (r_phase == rdpd_pkg::PH_IDLE) |-> !r_tone)
    `RDPD_ASSERT_NEXT(a_pickup_tone, w_accept && (r_phase == rdpd_pkg::PH_IDLE) && w_deb.rise, r_tone && (r_phase == rdpd_pkg::PH_WAIT_PULSE))

endmodule
